### rtl/drt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

	// Default number of stored regions.
	localparam int DEF_REGION_SLOTS = 16;

	// Field widths.
	localparam int COORD_W = 12;
	localparam int RECT_W  = 16;
	localparam int ENTRY_W = 4 * COORD_W;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 3;
	localparam int CFG_IDX_W = 2;

	// Command codes.
	localparam logic [1:0] CMD_MARK     = 2'd0;
	localparam logic [1:0] CMD_MARK_ALL = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd0;
	localparam logic [STAT_W-1:0] STAT_COVERED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_ADDED   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd3;
	localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_EN      = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
	localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd768;

	// Clipped rectangle as handed from the clip stage to the control.
	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} clip_res_t;

endpackage

`default_nettype wire

### rtl/drt_clip.sv
`timescale 1ns / 1ps
`default_nettype none

module drt_clip import drt_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      load,
	input  wire logic signed [RECT_W-1:0]  x,
	input  wire logic signed [RECT_W-1:0]  y,
	input  wire logic signed [RECT_W-1:0]  w,
	input  wire logic signed [RECT_W-1:0]  h,
	input  wire logic        [COORD_W-1:0] screen_w,
	input  wire logic        [COORD_W-1:0] screen_h,
	output clip_res_t                      res_q
);

	localparam int EXT_W = RECT_W + 3;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] start;
		logic [COORD_W-1:0] size;
	} dim_t;

	// Clips one axis: a negative start eats into the size, and the far edge
	// is pulled back to the screen limit.
	function automatic dim_t clip_dim(input logic signed [RECT_W-1:0] p,
	                                  input logic signed [RECT_W-1:0] s,
	                                  input logic [COORD_W-1:0] lim);
		logic signed [EXT_W-1:0] pa;
		logic signed [EXT_W-1:0] sa;
		logic signed [EXT_W-1:0] lm;
		logic signed [EXT_W-1:0] fe;
		dim_t d;
		pa = (p < 0) ? '0 : EXT_W'(p);
		sa = (p < 0) ? EXT_W'(s) + EXT_W'(p) : EXT_W'(s);
		lm = signed'({{(EXT_W-COORD_W){1'b0}}, lim});
		fe = pa + sa;
		if (fe > lm) begin
			sa = lm - pa;
		end
		d.ok    = (sa > 0);
		d.start = pa[COORD_W-1:0];
		d.size  = sa[COORD_W-1:0];
		return d;
	endfunction

	dim_t dx;
	dim_t dy;

	always_comb begin
		dx = clip_dim(x, w, screen_w);
		dy = clip_dim(y, h, screen_h);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.ok <= dx.ok && dy.ok;
			res_q.x  <= dx.start;
			res_q.y  <= dy.start;
			res_q.w  <= dx.size;
			res_q.h  <= dy.size;
		end
	end

endmodule

`default_nettype wire

### rtl/dirty_rect_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Dirty-rectangle tracker. Each input beat carries a command: mark a signed
// rectangle, mark the whole screen (which also raises the redraw request),
// or clear the list at the end of a render pass. A marked rectangle is
// clipped to the configured screen; if it is empty or already lies inside a
// stored region nothing changes, otherwise it is stored while a slot is free
// and the redraw flag is raised even when the list is full. Every input beat
// yields exactly one output beat with the status, the clipped rectangle, the
// region count and the redraw flag after the command. The regions live in a
// single-port synchronous memory that is scanned one entry per cycle, so a
// mark that scans the whole list takes longer the more regions are stored. A
// mark whose clipped rectangle is empty leaves the scan before any entry is
// read, and a mark that lands inside a stored region stops the scan at that
// entry. Clear, ignored commands and marks while tracking is off skip the
// clip and the scan and go straight to the done state. An output beat that
// is not taken holds the next result back but not the next input beat; the
// input stalls only once that next result is ready and waiting.
// Configuration writes are always accepted and must only be issued while no
// command is in flight; an unknown register index is ignored.
module dirty_rect_tracker import drt_pkg::*; #(
	parameter int REGION_SLOTS = DEF_REGION_SLOTS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [COORD_W-1:0]          cfg_data,

	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [1:0]                  cmd,
	input  wire logic signed [RECT_W-1:0]    rect_x,
	input  wire logic signed [RECT_W-1:0]    rect_y,
	input  wire logic signed [RECT_W-1:0]    rect_w,
	input  wire logic signed [RECT_W-1:0]    rect_h,

	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [STAT_W-1:0]           status,
	output      logic [COORD_W-1:0]          clip_x,
	output      logic [COORD_W-1:0]          clip_y,
	output      logic [COORD_W-1:0]          clip_w,
	output      logic [COORD_W-1:0]          clip_h,
	output      logic [COUNT_W-1:0]          entry_count,
	output      logic                        redraw_flag
);

	// The count must hold REGION_SLOTS itself; the memory index only needs
	// to reach the last slot.
	localparam int CNT_W = $clog2(REGION_SLOTS + 1);
	localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(REGION_SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CLIP = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [COORD_W-1:0] screen_w_q;
	logic [COORD_W-1:0] screen_h_q;
	logic               track_en_q;

	// Architectural state besides the region memory.
	logic [CNT_W-1:0]   count_q;
	logic               pending_q;

	// Rectangle latched at the input beat; mark-all loads the full screen.
	logic signed [RECT_W-1:0] rx_q;
	logic signed [RECT_W-1:0] ry_q;
	logic signed [RECT_W-1:0] rw_q;
	logic signed [RECT_W-1:0] rh_q;

	clip_res_t          clip_q;

	// Scan pipeline: one read issued per cycle, compared in the cycle after.
	logic [ENTRY_W-1:0] region_mem_q [REGION_SLOTS];
	logic [CNT_W-1:0]   issue_q;
	logic               rd_vld_s1;
	logic [ENTRY_W-1:0] rd_data_s1;

	logic [STAT_W-1:0]  res_status_q;
	logic               out_valid_q;

	logic               in_fire;
	logic               out_free;
	logic               hit;
	logic               scan_end;
	logic               mem_wr;
	logic               clip_load;
	logic               clip_shown;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign clip_load = (state_q == ST_CLIP);

	drt_clip u_clip (
		.clk      (clk),
		.load     (clip_load),
		.x        (rx_q),
		.y        (ry_q),
		.w        (rw_q),
		.h        (rh_q),
		.screen_w (screen_w_q),
		.screen_h (screen_h_q),
		.res_q    (clip_q)
	);

	// Containment test of the stored region that came out of the memory
	// against the clipped rectangle. Sums are one bit wider than a coordinate.
	always_comb begin
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [COORD_W-1:0] ew;
		logic [COORD_W-1:0] eh;
		{ex, ey, ew, eh} = rd_data_s1;
		hit = rd_vld_s1 &&
		      (ex <= clip_q.x) && (ey <= clip_q.y) &&
		      ({1'b0, ex} + {1'b0, ew} >= {1'b0, clip_q.x} + {1'b0, clip_q.w}) &&
		      ({1'b0, ey} + {1'b0, eh} >= {1'b0, clip_q.y} + {1'b0, clip_q.h});
	end

	// The scan is over once every stored entry has been read and the last
	// one has failed the containment test.
	assign scan_end = (state_q == ST_SCAN) && clip_q.ok && !hit && (issue_q == count_q);
	assign mem_wr   = scan_end && (count_q < SLOTS_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= RST_SCREEN_WIDTH;
			screen_h_q <= RST_SCREEN_HEIGHT;
			track_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_w_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_h_q <= cfg_data;
				REG_TRACK_EN:      track_en_q <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pending_q   <= 1'b1;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the done state the output register is either refilled or
			// still held, so the beat is only retired outside it.
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (cmd)
							CMD_MARK: begin
								state_q <= track_en_q ? ST_CLIP : ST_DONE;
							end
							CMD_MARK_ALL: begin
								pending_q <= 1'b1;
								state_q   <= track_en_q ? ST_CLIP : ST_DONE;
							end
							CMD_CLEAR: begin
								count_q   <= '0;
								pending_q <= 1'b0;
								state_q   <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CLIP: begin
					issue_q   <= '0;
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!clip_q.ok || hit) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DONE;
					end else if (scan_end) begin
						rd_vld_s1 <= 1'b0;
						pending_q <= 1'b1;
						if (mem_wr) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						rd_vld_s1 <= (issue_q < count_q);
						if (issue_q < count_q) begin
							issue_q <= issue_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input latch and result status; payload only.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (cmd == CMD_MARK_ALL) begin
				rx_q <= '0;
				ry_q <= '0;
				rw_q <= signed'(RECT_W'(screen_w_q));
				rh_q <= signed'(RECT_W'(screen_h_q));
			end else begin
				rx_q <= rect_x;
				ry_q <= rect_y;
				rw_q <= rect_w;
				rh_q <= rect_h;
			end
			res_status_q <= (cmd == CMD_CLEAR) ? STAT_CLEARED : STAT_IGNORED;
		end else if (state_q == ST_SCAN) begin
			if (!clip_q.ok) begin
				res_status_q <= STAT_IGNORED;
			end else if (hit) begin
				res_status_q <= STAT_COVERED;
			end else if (scan_end) begin
				res_status_q <= mem_wr ? STAT_ADDED : STAT_DROPPED;
			end
		end
	end

	// Region memory: one write or one read per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			region_mem_q[count_q[IDX_W-1:0]] <= {clip_q.x, clip_q.y, clip_q.w, clip_q.h};
		end else if ((state_q == ST_SCAN) && (issue_q < count_q)) begin
			rd_data_s1 <= region_mem_q[issue_q[IDX_W-1:0]];
		end
	end

	// Output register. Count and flag are the state after the command.
	assign clip_shown = (res_status_q == STAT_COVERED) || (res_status_q == STAT_ADDED) ||
	                    (res_status_q == STAT_DROPPED);

	logic [STAT_W-1:0]  o_status_q;
	logic [COORD_W-1:0] o_x_q;
	logic [COORD_W-1:0] o_y_q;
	logic [COORD_W-1:0] o_w_q;
	logic [COORD_W-1:0] o_h_q;
	logic [COUNT_W-1:0] o_count_q;
	logic               o_flag_q;

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			o_status_q <= res_status_q;
			o_x_q      <= clip_shown ? clip_q.x : '0;
			o_y_q      <= clip_shown ? clip_q.y : '0;
			o_w_q      <= clip_shown ? clip_q.w : '0;
			o_h_q      <= clip_shown ? clip_q.h : '0;
			o_count_q  <= COUNT_W'(count_q);
			o_flag_q   <= pending_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = o_status_q;
	assign clip_x      = o_x_q;
	assign clip_y      = o_y_q;
	assign clip_w      = o_w_q;
	assign clip_h      = o_h_q;
	assign entry_count = o_count_q;
	assign redraw_flag = o_flag_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_C)
		else $error("region count exceeds the number of slots");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output beat raised outside the done state");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |=> (count_q == $past(count_q) + 1'b1))
		else $error("region stored without advancing the count");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("memory read data pending outside the scan");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_CLEARED)) |-> ((entry_count == '0) && !redraw_flag))
		else $error("clear beat reports leftover state");
`endif

endmodule

`default_nettype wire

### tb/tb_dirty_rect_tracker.sv
`timescale 1ns / 1ps

// Self-checking bench for the dirty-rectangle tracker. A short scripted list of
// command beats comes first: it covers the coordinate extremes, every command,
// the full-screen mark and the unused command code. After that come phases of
// random beats, each one under its own screen size and tracking setting. The
// phases include a one-pixel screen, zero-width and zero-height screens, the
// largest screen and tracking switched off. A behavioral copy of the tracker in
// this module predicts every output beat, and a collector compares each output
// beat field by field against the oldest prediction.
module tb_dirty_rect_tracker;
	import drt_pkg::*;

	localparam int SLOTS       = DEF_REGION_SLOTS;
	localparam int LONG_HOLD   = 300;
	localparam int QUIET_LIMIT = 2000;

	// The command code that the block leaves unused, and a register index that
	// maps to no register. Both must be ignored.
	localparam logic [1:0]           CMD_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [RECT_W-1:0] x;
		logic [RECT_W-1:0] y;
		logic [RECT_W-1:0] w;
		logic [RECT_W-1:0] h;
	} command_beat_t;

	typedef struct packed {
		logic [STAT_W-1:0]  stat;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic [COUNT_W-1:0] count;
		logic               flag;
	} tracker_result_t;

	// One line of the scripted opening. When "known" is set, the expected beat
	// is written into the script by hand. Otherwise the predictor supplies it.
	typedef struct packed {
		command_beat_t   beat;
		logic            known;
		tracker_result_t want;
	} script_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_SCREEN_WIDTH;
	logic [COORD_W-1:0]       cfg_data  = '0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               cmd      = CMD_MARK;
	logic signed [RECT_W-1:0] rect_x   = '0;
	logic signed [RECT_W-1:0] rect_y   = '0;
	logic signed [RECT_W-1:0] rect_w   = '0;
	logic signed [RECT_W-1:0] rect_h   = '0;

	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STAT_W-1:0]        status;
	logic [COORD_W-1:0]       clip_x;
	logic [COORD_W-1:0]       clip_y;
	logic [COORD_W-1:0]       clip_w;
	logic [COORD_W-1:0]       clip_h;
	logic [COUNT_W-1:0]       entry_count;
	logic                     redraw_flag;

	dirty_rect_tracker #(
		.REGION_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.clip_x(clip_x),
		.clip_y(clip_y),
		.clip_w(clip_w),
		.clip_h(clip_h),
		.entry_count(entry_count),
		.redraw_flag(redraw_flag)
	);

	// The bench's copy of the tracker state and registers, starting from the
	// reset values.
	int   region_x [SLOTS];
	int   region_y [SLOTS];
	int   region_w [SLOTS];
	int   region_h [SLOTS];
	int   region_count   = 0;
	bit   redraw_pending = 1'b1;
	int   screen_w       = int'(RST_SCREEN_WIDTH);
	int   screen_h       = int'(RST_SCREEN_HEIGHT);
	bit   tracking_on    = 1'b1;

	tracker_result_t pending_results[$];
	script_row_t     script_rows[$];

	int beats_sent     = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int quiet_cycles   = 0;
	// This sets the chance of idling on both sides. A phase with a value of
	// zero runs with no gaps at all.
	int idle_pct       = 15;
	bit long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clipping works on 64-bit signed values, so a 16-bit corner plus a 16-bit
	// size can never wrap. When the clip leaves the rectangle empty, the result
	// is all zeros. Otherwise the stored regions are searched for one that
	// contains it. If none does, the redraw flag goes up and the rectangle is
	// stored, or it is dropped when every slot is taken.
	function automatic tracker_result_t clip_and_store(longint x, longint y,
			longint w, longint h);
		tracker_result_t r;
		int              i;
		r = '0;
		if (x < 0) begin
			w += x;
			x = 0;
		end
		if (y < 0) begin
			h += y;
			y = 0;
		end
		if (x + w > screen_w) w = screen_w - x;
		if (y + h > screen_h) h = screen_h - y;
		if (w <= 0 || h <= 0) return r;
		r.x = COORD_W'(x);
		r.y = COORD_W'(y);
		r.w = COORD_W'(w);
		r.h = COORD_W'(h);
		for (i = 0; i < region_count; i++) begin
			if (region_x[i] <= x && region_y[i] <= y &&
					region_x[i] + region_w[i] >= x + w &&
					region_y[i] + region_h[i] >= y + h) begin
				r.stat = STAT_COVERED;
				return r;
			end
		end
		redraw_pending = 1'b1;
		if (region_count < SLOTS) begin
			region_x[region_count] = int'(x);
			region_y[region_count] = int'(y);
			region_w[region_count] = int'(w);
			region_h[region_count] = int'(h);
			region_count++;
			r.stat = STAT_ADDED;
		end else begin
			r.stat = STAT_DROPPED;
		end
		return r;
	endfunction

	// Advances the bench's copy of the tracker by one command beat and returns
	// the output beat that the command should produce.
	function automatic tracker_result_t apply_command(command_beat_t b);
		tracker_result_t r;
		r = '0;
		case (b.op)
			CMD_MARK: begin
				if (tracking_on)
					r = clip_and_store(longint'($signed(b.x)), longint'($signed(b.y)),
						longint'($signed(b.w)), longint'($signed(b.h)));
			end
			CMD_MARK_ALL: begin
				// The flag goes up even while tracking is off.
				redraw_pending = 1'b1;
				if (tracking_on)
					r = clip_and_store(0, 0, screen_w, screen_h);
			end
			CMD_CLEAR: begin
				region_count   = 0;
				redraw_pending = 1'b0;
				r.stat         = STAT_CLEARED;
			end
			default: ;
		endcase
		r.count = COUNT_W'(region_count);
		r.flag  = redraw_pending;
		return r;
	endfunction

	task automatic note_mismatch(input string what);
		$display("MISMATCH at output beat %0d: %s", results_seen, what);
		mismatches++;
	endtask

	task automatic check_result(input tracker_result_t want, input tracker_result_t got);
		if (got.stat !== want.stat)
			note_mismatch($sformatf("status %0d, expected %0d", got.stat, want.stat));
		if (got.x !== want.x)
			note_mismatch($sformatf("clip_x %0d, expected %0d", got.x, want.x));
		if (got.y !== want.y)
			note_mismatch($sformatf("clip_y %0d, expected %0d", got.y, want.y));
		if (got.w !== want.w)
			note_mismatch($sformatf("clip_w %0d, expected %0d", got.w, want.w));
		if (got.h !== want.h)
			note_mismatch($sformatf("clip_h %0d, expected %0d", got.h, want.h));
		if (got.count !== want.count)
			note_mismatch($sformatf("entry_count %0d, expected %0d", got.count, want.count));
		if (got.flag !== want.flag)
			note_mismatch($sformatf("redraw_flag %0d, expected %0d", got.flag, want.flag));
	endtask

	// Collects output beats. The values are read at the clock edge, before
	// any assignment made in the same time step takes effect.
	always @(posedge clk) begin : collect
		tracker_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {status, clip_x, clip_y, clip_w, clip_h, entry_count, redraw_flag};
			if (pending_results.size() == 0)
				note_mismatch("output beat arrived with nothing expected");
			else
				check_result(pending_results.pop_front(), got);
			results_seen++;
		end
	end

	// This counts cycles in which no handshake completes on any channel. A
	// hung block ends the run here.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("No handshake for %0d cycles", quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Output side. It takes beats with random stall bursts. Once, partway
	// through the run, it holds off for a long stretch. The sender keeps
	// offering beats during that time, so the block backs up and must stall
	// its input.
	initial begin : receiver
		int burst;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!long_hold_done && results_seen >= 400) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
				burst = $urandom_range(1, 8);
				out_ready <= 1'b0;
				repeat (burst) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Puts one command beat on the input and holds it until the block accepts
	// it. The prediction is made at the edge that accepts the beat. Valid stays
	// high afterward, so the caller either offers the next beat or lowers it.
	task automatic offer_beat(input command_beat_t b, input logic known,
			input tracker_result_t want);
		tracker_result_t predicted;
		in_valid <= 1'b1;
		cmd      <= b.op;
		rect_x   <= b.x;
		rect_y   <= b.y;
		rect_w   <= b.w;
		rect_h   <= b.h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = apply_command(b);
		pending_results.push_back(known ? want : predicted);
		beats_sent++;
	endtask

	task automatic maybe_pause();
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The sender stops and waits until every outstanding command has produced
	// its output beat. Only then is the block idle and safe to reconfigure.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (results_seen < beats_sent) @(posedge clk);
	endtask

	// Writes one register. Valid is left high, so writes can follow back to
	// back. The caller lowers valid after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SCREEN_WIDTH:  screen_w    = int'(val);
			REG_SCREEN_HEIGHT: screen_h    = int'(val);
			REG_TRACK_EN:      tracking_on = val[0];
			default: ;
		endcase
	endtask

	task automatic put_row(input logic [1:0] op, input int x, input int y, input int w,
			input int h, input logic known, input logic [STAT_W-1:0] st, input int cx,
			input int cy, input int cw, input int ch, input int cnt, input logic flg);
		script_row_t row;
		row.beat  = '{op, RECT_W'(x), RECT_W'(y), RECT_W'(w), RECT_W'(h)};
		row.known = known;
		row.want  = '{st, COORD_W'(cx), COORD_W'(cy), COORD_W'(cw), COORD_W'(ch),
			COUNT_W'(cnt), flg};
		script_rows.push_back(row);
	endtask

	// This picks a value at or near one of the extremes: the ends of the
	// 16-bit range, zero and one, or the screen edge.
	function automatic int pick_extreme(input int span);
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			4: return 32767;
			5: return span;
			6: return span - 1;
			default: return span + 1;
		endcase
	endfunction

	// Random traffic is shaped as runs that each open with a clear and are
	// then filled with marks, so the table fills up and rectangles get
	// dropped. A few stray clears break runs short. Mark-alls and unused codes
	// are mixed in as well. Mark rectangles are mostly small ones near the
	// screen or pieces of a stored region. The rest are extremes and fully
	// random bit patterns.
	task automatic run_phase(input int n_items);
		command_beat_t b;
		int            run_left, sel, k, i, x, y, w, h;
		run_left = 0;
		repeat (n_items) begin
			b.op = CMD_MARK;
			if (run_left == 0) begin
				b.op     = CMD_CLEAR;
				run_left = $urandom_range(4, 30);
			end else begin
				run_left--;
				sel = $urandom_range(0, 99);
				if (sel < 8)
					b.op = CMD_MARK_ALL;
				else if (sel < 11)
					b.op = CMD_RESERVED;
				else if (sel < 13)
					b.op = CMD_CLEAR;
			end
			k = $urandom_range(0, 99);
			if (b.op != CMD_MARK || k >= 85) begin
				x = $urandom;
				y = $urandom;
				w = $urandom;
				h = $urandom;
			end else if (k >= 70) begin
				x = pick_extreme(screen_w);
				y = pick_extreme(screen_h);
				w = pick_extreme(screen_w);
				h = pick_extreme(screen_h);
			end else if (k >= 45 && region_count != 0) begin
				i = $urandom_range(0, region_count - 1);
				x = region_x[i] + $urandom_range(0, region_w[i] - 1);
				y = region_y[i] + $urandom_range(0, region_h[i] - 1);
				w = $urandom_range(1, region_x[i] + region_w[i] - x);
				h = $urandom_range(1, region_y[i] + region_h[i] - y);
			end else begin
				x = int'($urandom_range(0, screen_w + 16)) - 8;
				y = int'($urandom_range(0, screen_h + 16)) - 8;
				w = int'($urandom_range(0, screen_w / 4 + 8)) - 4;
				h = int'($urandom_range(0, screen_h / 4 + 8)) - 4;
			end
			b.x = RECT_W'(x);
			b.y = RECT_W'(y);
			b.w = RECT_W'(w);
			b.h = RECT_W'(h);
			offer_beat(b, 1'b0, '0);
			maybe_pause();
		end
	endtask

	initial begin : driver
		int p, pw, ph, pn, pidle;
		logic pt;

		// Scripted opening. The block starts from reset with a 1024 x 768
		// screen, tracking on, an empty table and the redraw flag raised.
		put_row(CMD_CLEAR, 0, 0, 0, 0, 1, STAT_CLEARED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK, 0, 0, 0, 0, 1, STAT_IGNORED, 0, 0, 0, 0, 0, 0);
		// The most negative corner: moving it onto the screen eats the width.
		put_row(CMD_MARK, -32768, -32768, 32767, 32767, 1, STAT_IGNORED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK, 10, 20, 100, 50, 1, STAT_ADDED, 10, 20, 100, 50, 1, 1);
		put_row(CMD_MARK, 20, 30, 10, 10, 1, STAT_COVERED, 20, 30, 10, 10, 1, 1);
		// The most positive corner lies far off the screen.
		put_row(CMD_MARK, 32767, 32767, 32767, 32767, 1, STAT_IGNORED, 0, 0, 0, 0, 1, 1);
		put_row(CMD_MARK, -5, -7, -32768, 100, 1, STAT_IGNORED, 0, 0, 0, 0, 1, 1);
		put_row(CMD_MARK, 1000, 700, 100, 100, 1, STAT_ADDED, 1000, 700, 24, 68, 2, 1);
		put_row(CMD_MARK, -100, -100, 32767, 32767, 1, STAT_ADDED, 0, 0, 1024, 768, 3, 1);
		put_row(CMD_MARK, 500, 500, 10, 10, 1, STAT_COVERED, 500, 500, 10, 10, 3, 1);
		put_row(CMD_MARK_ALL, 0, 0, 0, 0, 1, STAT_COVERED, 0, 0, 1024, 768, 3, 1);
		put_row(CMD_RESERVED, -1, -1, -1, -1, 1, STAT_IGNORED, 0, 0, 0, 0, 3, 1);
		put_row(CMD_CLEAR, -1, -1, -1, -1, 1, STAT_CLEARED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_RESERVED, 0, 0, 0, 0, 1, STAT_IGNORED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK_ALL, 0, 0, 0, 0, 1, STAT_ADDED, 0, 0, 1024, 768, 1, 1);
		put_row(CMD_MARK, 1023, 767, 1, 1, 1, STAT_COVERED, 1023, 767, 1, 1, 1, 1);
		put_row(CMD_MARK, 1024, 0, 5, 5, 1, STAT_IGNORED, 0, 0, 0, 0, 1, 1);
		put_row(CMD_CLEAR, 0, 0, 0, 0, 1, STAT_CLEARED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK, 1023, 767, 32767, 32767, 0, STAT_IGNORED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK, 0, 0, 1, 1, 0, STAT_IGNORED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK, -32768, 767, -32768, 32767, 0, STAT_IGNORED, 0, 0, 0, 0, 0, 0);
		put_row(CMD_MARK, 512, -1, 32767, 2, 0, STAT_IGNORED, 0, 0, 0, 0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_rows[i]) begin
			offer_beat(script_rows[i].beat, script_rows[i].known, script_rows[i].want);
			maybe_pause();
		end
		wait_all_results();

		// Each phase opens with the block idle and every register rewritten.
		// A write to the unused index comes first, and it must change nothing.
		// The last phase runs without idling on either side.
		for (p = 0; p < 9; p++) begin
			case (p)
				0: begin pw = 4095; ph = 4095; pt = 1'b1; pn = 200; pidle = 20; end
				1: begin pw = 1;    ph = 1;    pt = 1'b1; pn = 80;  pidle = 0;  end
				2: begin pw = 0;    ph = 300;  pt = 1'b1; pn = 80;  pidle = 30; end
				3: begin pw = 320;  ph = 0;    pt = 1'b1; pn = 80;  pidle = 10; end
				4: begin pw = 640;  ph = 480;  pt = 1'b0; pn = 120; pidle = 20; end
				5: begin pw = 4095; ph = 1;    pt = 1'b1; pn = 150; pidle = 0;  end
				6: begin
					pw = $urandom_range(1, 4095);
					ph = $urandom_range(1, 4095);
					pt = 1'b1;
					pn = 250;
					pidle = 30;
				end
				7: begin pw = 64;   ph = 48;   pt = 1'b1; pn = 250; pidle = 15; end
				default: begin pw = 1024; ph = 768; pt = 1'b1; pn = 150; pidle = 0; end
			endcase
			write_reg(REG_UNUSED, COORD_W'($urandom));
			write_reg(REG_SCREEN_WIDTH, COORD_W'(pw));
			write_reg(REG_SCREEN_HEIGHT, COORD_W'(ph));
			write_reg(REG_TRACK_EN, {11'($urandom), pt});
			cfg_valid <= 1'b0;
			idle_pct = pidle;
			run_phase(pn);
			wait_all_results();
		end

		repeat (40) @(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch($sformatf("%0d expected beats never arrived", pending_results.size()));
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
